// ===== hdl/stopword_filtered_sentence_hash_core_assert.svh =====
// ----------------------------------------------------------------------------
// stopword_filtered_sentence_hash_core_assert
// Assertion helper macros for the sentence hash core checker.
// ----------------------------------------------------------------------------
`ifndef STOPWORD_FILTERED_SENTENCE_HASH_CORE_ASSERT_SVH
`define STOPWORD_FILTERED_SENTENCE_HASH_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define SFSH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SFSH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sfsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfsh_pkg
// Shared types, constants and tables of the stopword filtered sentence hash.
// ----------------------------------------------------------------------------
package sfsh_pkg;

    typedef logic [7:0] t_byte;

    // Character codes
    localparam t_byte CH_TAB   = 8'd9;
    localparam t_byte CH_SPACE = 8'd32;
    localparam t_byte NUL      = 8'h00;

    // Sentence limits and field widths
    localparam logic [3:0] MAX_WORDS     = 4'd11;
    localparam logic [3:0] MAX_CONTENT   = 4'd5;
    localparam int         WORD_CNT_W    = 4;
    localparam int         CONTENT_CNT_W = 3;
    localparam int         MASK_W        = 11;
    localparam int         WHASH_W       = 16;
    localparam int         SHASH_W       = 24;

    // Hash constants
    localparam logic [4:0]          WORD_MULT = 5'd31;
    localparam logic [WHASH_W-1:0]  WORD_MOD  = 16'd45677;
    localparam logic [SHASH_W-1:0]  SENT_MOD  = 24'd9999991;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_WORDS   = 2'd1,
        STATUS_CONTENT = 2'd2
    } t_status;

    // Preposition list, one byte per letter, zero padded
    localparam int NUM_PREPS    = 20;
    localparam int PREP_MAX_LEN = 8;
    localparam int POS_W        = 4;
    localparam logic [POS_W-1:0] POS_SAT = 4'd8;

    typedef logic [NUM_PREPS-1:0] t_prep_vec;

    localparam t_byte PREP_CHARS [NUM_PREPS][PREP_MAX_LEN] = '{
        '{"o", "f", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"t", "o", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"i", "n", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"f", "o", "r", NUL, NUL, NUL, NUL, NUL},
        '{"w", "i", "t", "h", NUL, NUL, NUL, NUL},
        '{"o", "n", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"a", "t", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"b", "y", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"f", "r", "o", "m", NUL, NUL, NUL, NUL},
        '{"u", "p", NUL, NUL, NUL, NUL, NUL, NUL},
        '{"a", "b", "o", "u", "t", NUL, NUL, NUL},
        '{"t", "h", "a", "n", NUL, NUL, NUL, NUL},
        '{"a", "f", "t", "e", "r", NUL, NUL, NUL},
        '{"b", "e", "f", "o", "r", "e", NUL, NUL},
        '{"d", "o", "w", "n", NUL, NUL, NUL, NUL},
        '{"b", "e", "t", "w", "e", "e", "n", NUL},
        '{"u", "n", "d", "e", "r", NUL, NUL, NUL},
        '{"s", "i", "n", "c", "e", NUL, NUL, NUL},
        '{"w", "i", "t", "h", "o", "u", "t", NUL},
        '{"n", "e", "a", "r", NUL, NUL, NUL, NUL}
    };

    localparam logic [POS_W-1:0] PREP_LEN [NUM_PREPS] = '{
        4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd2, 4'd2, 4'd2, 4'd4, 4'd2,
        4'd5, 4'd4, 4'd5, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7, 4'd4
    };

    // Matcher status handed to the top level
    typedef struct packed {
        t_prep_vec        alive;
        logic [POS_W-1:0] pos;
        logic             is_prep;
    } t_match;

    // H*65537 = H*2^16 + H. The byte-wise terms of H*2^16 that reach past
    // 2^24 are reduced through two 256-entry residue tables.
    localparam logic [SHASH_W-1:0] SH32_STEP = 24'((64'd1 << 32) % 64'(SENT_MOD));
    localparam logic [SHASH_W-1:0] SH24_STEP = 24'((64'd1 << 24) % 64'(SENT_MOD));

    typedef logic [SHASH_W-1:0] t_hash_tab [256];

    // tab[b] = b*step mod SENT_MOD, built by repeated add and reduce
    function automatic t_hash_tab build_tab(input logic [SHASH_W-1:0] step);
        t_hash_tab         tab;
        logic [SHASH_W:0]  acc;
        acc = '0;
        for (int b = 0; b < 256; b++) begin
            tab[b] = acc[SHASH_W-1:0];
            acc = acc + {1'b0, step};
            if (acc >= {1'b0, SENT_MOD}) begin
                acc = acc - {1'b0, SENT_MOD};
            end
        end
        return tab;
    endfunction

    localparam t_hash_tab SH32_TAB = build_tab(SH32_STEP);
    localparam t_hash_tab SH24_TAB = build_tab(SH24_STEP);

endpackage

// ===== hdl/sfsh_prep_match.sv =====
// ----------------------------------------------------------------------------
// sfsh_prep_match
// Preposition matcher: one candidate bit per list entry, narrowed per letter.
// ----------------------------------------------------------------------------
module sfsh_prep_match (
    input  sfsh_pkg::t_prep_vec           i_alive,
    input  logic [sfsh_pkg::POS_W-1:0]    i_pos,
    input  sfsh_pkg::t_byte               i_char,
    output sfsh_pkg::t_match              o_match
);

    always_comb begin : match_step
        logic [2:0] idx;
        idx = i_pos[2:0];
        o_match.is_prep = 1'b0;
        for (int p = 0; p < sfsh_pkg::NUM_PREPS; p++) begin
            // pos < len keeps idx inside the entry (longest entry is 7)
            o_match.alive[p] = i_alive[p] && (i_pos < sfsh_pkg::PREP_LEN[p])
                               && (sfsh_pkg::PREP_CHARS[p][idx] == i_char);
            // word so far equals the whole entry
            if (i_alive[p] && (i_pos == sfsh_pkg::PREP_LEN[p])) begin
                o_match.is_prep = 1'b1;
            end
        end
        o_match.pos = (i_pos == sfsh_pkg::POS_SAT) ? i_pos : i_pos + 4'd1;
    end

endmodule

// ===== hdl/sfsh_hash_step.sv =====
// ----------------------------------------------------------------------------
// sfsh_hash_step
// Word hash update and sentence hash fold, both with constant modulus.
// ----------------------------------------------------------------------------
module sfsh_hash_step (
    input  logic [sfsh_pkg::WHASH_W-1:0] i_word_hash,
    input  sfsh_pkg::t_byte              i_char,
    input  logic [sfsh_pkg::SHASH_W-1:0] i_run_hash,
    output logic [sfsh_pkg::WHASH_W-1:0] o_word_hash_nxt,
    output logic [sfsh_pkg::SHASH_W-1:0] o_run_hash_nxt
);

    // h*31 + ch < 32*WORD_MOD: five restoring subtract steps
    always_comb begin : word_step
        logic [20:0] acc;
        acc = 21'(i_word_hash) * 21'(sfsh_pkg::WORD_MULT) + 21'(i_char);
        for (int k = 4; k >= 0; k--) begin
            if (acc >= (21'(sfsh_pkg::WORD_MOD) << k)) begin
                acc = acc - (21'(sfsh_pkg::WORD_MOD) << k);
            end
        end
        o_word_hash_nxt = acc[sfsh_pkg::WHASH_W-1:0];
    end

    // H*2^16 + H + h, high bytes through residue tables; sum < 5*SENT_MOD
    always_comb begin : sent_fold
        logic [25:0] sum;
        sum = 26'(sfsh_pkg::SH32_TAB[i_run_hash[23:16]])
            + 26'(sfsh_pkg::SH24_TAB[i_run_hash[15:8]])
            + 26'({i_run_hash[7:0], 16'h0000})
            + 26'(i_run_hash)
            + 26'(i_word_hash);
        for (int k = 2; k >= 0; k--) begin
            if (sum >= (26'(sfsh_pkg::SENT_MOD) << k)) begin
                sum = sum - (26'(sfsh_pkg::SENT_MOD) << k);
            end
        end
        o_run_hash_nxt = sum[sfsh_pkg::SHASH_W-1:0];
    end

endmodule

// ===== hdl/stopword_filtered_sentence_hash_core.sv =====
// ----------------------------------------------------------------------------
// stopword_filtered_sentence_hash_core
// Splits a byte stream into words, drops prepositions, hashes the rest.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | request   | i_in_valid / o_in_ready   | i_char_code
//  out     | result    | o_out_valid / i_out_ready | o_sentence_hash, o_status,
//          |           |                           | o_word_count, o_content_count,
//          |           |                           | o_content_mask
//
//  One byte per cycle. A byte lands in the input register, and when it moves
//  on, all per-byte work (word hash, preposition match, sentence fold) runs
//  into the state and, on a tab, into the result register. Reset
//  (synchronous, active low) clears the sentence state and empties both
//  registers. A held result stalls only a tab; space and letter requests keep
//  flowing behind it.
//
//  Word boundaries: space ends a word, tab ends the sentence. Words with a
//  byte outside a..z never match a preposition. Once a limit is hit the rest
//  of the sentence up to the tab is dropped.
// ----------------------------------------------------------------------------
module stopword_filtered_sentence_hash_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_char_code,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [23:0]                         o_sentence_hash,
    output logic [1:0]                          o_status,
    output logic [3:0]                          o_word_count,
    output logic [2:0]                          o_content_count,
    output logic [10:0]                         o_content_mask
);

    // input register
    logic                                   r_s1_valid;
    sfsh_pkg::t_byte                        r_s1_char;

    // sentence state
    logic [sfsh_pkg::WHASH_W-1:0]           r_word_hash,  n_word_hash;
    logic [sfsh_pkg::SHASH_W-1:0]           r_run_hash,   n_run_hash;
    logic [sfsh_pkg::WORD_CNT_W-1:0]        r_words,      n_words;
    logic [sfsh_pkg::CONTENT_CNT_W-1:0]     r_content,    n_content;
    logic [sfsh_pkg::MASK_W-1:0]            r_mask,       n_mask;
    sfsh_pkg::t_prep_vec                    r_alive,      n_alive;
    logic [sfsh_pkg::POS_W-1:0]             r_pos,        n_pos;
    sfsh_pkg::t_status                      r_err,        n_err;

    // result register
    logic                                   r_out_valid,  n_out_valid;
    logic [sfsh_pkg::SHASH_W-1:0]           r_out_hash,   n_out_hash;
    sfsh_pkg::t_status                      r_out_status, n_out_status;
    logic [sfsh_pkg::WORD_CNT_W-1:0]        r_out_words,  n_out_words;
    logic [sfsh_pkg::CONTENT_CNT_W-1:0]     r_out_content, n_out_content;
    logic [sfsh_pkg::MASK_W-1:0]            r_out_mask,   n_out_mask;

    // per-byte logic
    logic                                   is_tab;
    logic                                   is_space;
    logic                                   out_free;
    logic                                   s1_go;
    sfsh_pkg::t_match                       match;
    logic [sfsh_pkg::WHASH_W-1:0]           word_hash_nxt;
    logic [sfsh_pkg::SHASH_W-1:0]           run_hash_fold;

    // word-end bookkeeping, shared by space and tab
    logic                                   fw_content;
    logic                                   fw_overflow;
    logic [sfsh_pkg::WORD_CNT_W-1:0]        fw_words;
    logic [sfsh_pkg::CONTENT_CNT_W-1:0]     fw_content_cnt;
    logic [sfsh_pkg::MASK_W-1:0]            fw_mask;
    logic [sfsh_pkg::SHASH_W-1:0]           fw_hash;

    sfsh_prep_match u_prep_match (
        .i_alive    (r_alive),
        .i_pos      (r_pos),
        .i_char     (r_s1_char),
        .o_match    (match)
    );

    sfsh_hash_step u_hash_step (
        .i_word_hash     (r_word_hash),
        .i_char          (r_s1_char),
        .i_run_hash      (r_run_hash),
        .o_word_hash_nxt (word_hash_nxt),
        .o_run_hash_nxt  (run_hash_fold)
    );

    assign is_tab   = (r_s1_char == sfsh_pkg::CH_TAB);
    assign is_space = (r_s1_char == sfsh_pkg::CH_SPACE);

    // only a tab needs a free result slot
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_go      = r_s1_valid && (!is_tab || out_free);
    assign o_in_ready = !r_s1_valid || s1_go;

    assign fw_content     = !match.is_prep;
    assign fw_overflow    = fw_content && ({1'b0, r_content} >= sfsh_pkg::MAX_CONTENT);
    assign fw_words       = r_words + 4'd1;
    assign fw_content_cnt = fw_content ? r_content + 3'd1 : r_content;
    assign fw_mask        = fw_content ? (r_mask | (11'd1 << r_words)) : r_mask;
    assign fw_hash        = fw_content ? run_hash_fold : r_run_hash;

    always_comb begin
        n_word_hash   = r_word_hash;
        n_run_hash    = r_run_hash;
        n_words       = r_words;
        n_content     = r_content;
        n_mask        = r_mask;
        n_alive       = r_alive;
        n_pos         = r_pos;
        n_err         = r_err;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_hash    = r_out_hash;
        n_out_status  = r_out_status;
        n_out_words   = r_out_words;
        n_out_content = r_out_content;
        n_out_mask    = r_out_mask;

        if (s1_go) begin
            if (is_tab) begin
                // close the last word, emit, then start a fresh sentence
                n_out_valid = 1'b1;
                if (r_err != sfsh_pkg::STATUS_OK) begin
                    n_out_status  = r_err;
                    n_out_hash    = '0;
                    n_out_words   = r_words;
                    n_out_content = r_content;
                    n_out_mask    = r_mask;
                end else if (fw_overflow) begin
                    n_out_status  = sfsh_pkg::STATUS_CONTENT;
                    n_out_hash    = '0;
                    n_out_words   = r_words;
                    n_out_content = r_content;
                    n_out_mask    = r_mask;
                end else begin
                    n_out_status  = sfsh_pkg::STATUS_OK;
                    n_out_hash    = fw_hash;
                    n_out_words   = fw_words;
                    n_out_content = fw_content_cnt;
                    n_out_mask    = fw_mask;
                end
                n_word_hash = '0;
                n_run_hash  = '0;
                n_words     = '0;
                n_content   = '0;
                n_mask      = '0;
                n_alive     = '1;
                n_pos       = '0;
                n_err       = sfsh_pkg::STATUS_OK;
            end else if (r_err == sfsh_pkg::STATUS_OK) begin
                if (is_space) begin
                    if (r_words >= sfsh_pkg::MAX_WORDS - 4'd1) begin
                        // word limit: this word is not classified
                        n_err = sfsh_pkg::STATUS_WORDS;
                    end else if (fw_overflow) begin
                        n_err = sfsh_pkg::STATUS_CONTENT;
                    end else begin
                        n_run_hash  = fw_hash;
                        n_words     = fw_words;
                        n_content   = fw_content_cnt;
                        n_mask      = fw_mask;
                        n_word_hash = '0;
                        n_alive     = '1;
                        n_pos       = '0;
                    end
                end else begin
                    n_word_hash = word_hash_nxt;
                    n_alive     = match.alive;
                    n_pos       = match.pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_word_hash <= '0;
            r_run_hash  <= '0;
            r_words     <= '0;
            r_content   <= '0;
            r_mask      <= '0;
            r_alive     <= '1;
            r_pos       <= '0;
            r_err       <= sfsh_pkg::STATUS_OK;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
            r_word_hash <= n_word_hash;
            r_run_hash  <= n_run_hash;
            r_words     <= n_words;
            r_content   <= n_content;
            r_mask      <= n_mask;
            r_alive     <= n_alive;
            r_pos       <= n_pos;
            r_err       <= n_err;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_char <= i_char_code;
        end
        r_out_hash    <= n_out_hash;
        r_out_status  <= n_out_status;
        r_out_words   <= n_out_words;
        r_out_content <= n_out_content;
        r_out_mask    <= n_out_mask;
    end

    assign o_out_valid     = r_out_valid;
    assign o_sentence_hash = r_out_hash;
    assign o_status        = r_out_status;
    assign o_word_count    = r_out_words;
    assign o_content_count = r_out_content;
    assign o_content_mask  = r_out_mask;

endmodule

// ===== hdl/sfsh_checker.sv =====
// ----------------------------------------------------------------------------
// sfsh_checker
// Port-level checks of the sentence hash core, bound to the top level.
// ----------------------------------------------------------------------------
`include "stopword_filtered_sentence_hash_core_assert.svh"

module sfsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_char_code,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_sentence_hash,
    input logic [1:0]  o_status,
    input logic [3:0]  o_word_count,
    input logic [2:0]  o_content_count,
    input logic [10:0] o_content_mask
);

    // held result stays put
    property p_out_hold;
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sentence_hash)
            && $stable(o_status) && $stable(o_word_count)
            && $stable(o_content_count) && $stable(o_content_mask);
    endproperty

    // waiting request keeps its byte
    property p_in_hold;
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_char_code);
    endproperty

    // mask bits and content count move together; content words are words
    property p_mask_count;
        o_out_valid |-> ($countones(o_content_mask) == o_content_count)
            && (o_content_count <= o_word_count);
    endproperty

    // field ranges; a failed sentence carries no hash
    property p_fields;
        o_out_valid |-> (o_sentence_hash < sfsh_pkg::SENT_MOD)
            && (o_word_count <= sfsh_pkg::MAX_WORDS)
            && (o_status <= sfsh_pkg::STATUS_CONTENT)
            && ((o_status == sfsh_pkg::STATUS_OK) || (o_sentence_hash == 24'd0));
    endproperty

    // reset empties the result slot
    property p_rst_empty;
        !i_rst_n |=> !o_out_valid;
    endproperty

    `SFSH_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "result changed while stalled")
    `SFSH_ASSERT(a_in_hold, i_clk, i_rst_n, p_in_hold, "request changed while waiting")
    `SFSH_ASSERT(a_mask_count, i_clk, i_rst_n, p_mask_count, "mask and counts disagree")
    `SFSH_ASSERT(a_fields, i_clk, i_rst_n, p_fields, "result field out of range")
    `SFSH_ASSERT_ALWAYS(a_rst_empty, i_clk, p_rst_empty, "result valid after reset")

endmodule

bind stopword_filtered_sentence_hash_core sfsh_checker u_sfsh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_char_code     (i_char_code),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_sentence_hash (o_sentence_hash),
    .o_status        (o_status),
    .o_word_count    (o_word_count),
    .o_content_count (o_content_count),
    .o_content_mask  (o_content_mask)
);
